[hdl/frwa_pkg.sv]
// Shared constants and register codes for the frame rate window average block.
package frwa_pkg;

  localparam int FW              = 20;        // frame time and rate field width
  localparam int WIN_W           = 8;         // window_length register width
  localparam int PER_W           = 16;        // update_period register width
  localparam int CFG_AW          = 1;
  localparam int CFG_DW          = 16;
  localparam int MAX_SAMPLES_DEF = 128;

  localparam logic [FW-1:0]    DEFAULT_FRAME_US = 20'd16700;
  localparam logic [FW-1:0]    RESET_RATE       = 20'd60;
  localparam logic [WIN_W-1:0] RESET_WINDOW     = 8'd60;
  localparam logic [PER_W-1:0] RESET_PERIOD     = 16'd15;
  localparam longint unsigned  US_X2            = 64'd2000000;

  typedef enum logic [CFG_AW-1:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_UPDATE_PERIOD = 1'b1
  } reg_idx_t;

endpackage

[hdl/frwa_store.sv]
// Frame time sample memory with a post-reset fill pass to the default frame time.
module frwa_store #(
  parameter int DEPTH = frwa_pkg::MAX_SAMPLES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [frwa_pkg::FW-1:0] wr_data,
  input  logic [AW-1:0]           rd_addr,
  output logic [frwa_pkg::FW-1:0] rd_data,
  output logic                    busy
);

  logic [frwa_pkg::FW-1:0] mem [DEPTH];
  logic [AW-1:0]           clr_idx_r;
  logic                    busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      busy_r    <= 1'b1;
    end else if (busy_r) begin
      if (clr_idx_r == AW'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_idx_r] <= frwa_pkg::DEFAULT_FRAME_US;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign busy = busy_r;

endmodule

[hdl/frwa_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module frwa_div #(
  parameter int NUMW = 31,
  parameter int DENW = 28
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            done,
  output logic [NUMW-1:0] quo
);

  localparam int CW = $clog2(NUMW + 1);

  logic [NUMW-1:0] num_sh_r;
  logic [DENW-1:0] den_r;
  logic [DENW-1:0] rem_r;
  logic [NUMW-1:0] quo_r;
  logic [CW-1:0]   cnt_r;
  logic            run_r;
  logic            done_r;
  logic [DENW:0]   trial;
  logic            qbit;

  assign trial = {rem_r, num_sh_r[NUMW-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_sh_r <= num;
        den_r    <= den;
        rem_r    <= '0;
        quo_r    <= '0;
        cnt_r    <= CW'(NUMW);
        run_r    <= 1'b1;
      end else if (run_r) begin
        num_sh_r <= {num_sh_r[NUMW-2:0], 1'b0};
        rem_r    <= qbit ? DENW'(trial - {1'b0, den_r}) : trial[DENW-1:0];
        quo_r    <= {quo_r[NUMW-2:0], qbit};
        cnt_r    <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[hdl/frame_rate_window_average.sv]
// Moving-average frame rate meter: ring of frame times, periodic sum and serial divide.
// Each item is one frame time in microseconds and yields one result with the held rate.
// An item that does not trigger a recomputation goes straight to the output. One that does
// first sums the window (one memory read per cycle), then divides bit-serially, and then
// presents the result. A stalled output holds off the next item. After reset the sample
// memory is filled with 16700 us. No item is taken during the fill; configuration writes
// are taken.
module frame_rate_window_average #(
  parameter int MAX_SAMPLES = frwa_pkg::MAX_SAMPLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,   // [19:0] frame_time_us
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,  // [19:0] frames_per_second
  output logic                        out_tuser,  // [0] rate_updated
  input  logic                        cfg_wr_en,
  input  logic [frwa_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [frwa_pkg::CFG_DW-1:0] cfg_wdata
);

  localparam int FW   = frwa_pkg::FW;
  localparam int AW   = $clog2(MAX_SAMPLES);
  localparam int NW   = $clog2(MAX_SAMPLES + 1);
  localparam int SW   = FW + AW;
  localparam int NUMW = SW + 2;
  localparam int DENW = SW + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_DIV, ST_OUT} state_t;

  state_t                     state_r;
  logic [frwa_pkg::WIN_W-1:0] win_len_r;
  logic [frwa_pkg::PER_W-1:0] period_r;
  logic [AW-1:0]              wp_r;
  logic [frwa_pkg::PER_W-1:0] cnt_r;
  logic [FW-1:0]              held_r;
  logic [NW-1:0]              n_r;
  logic [NW-1:0]              rd_idx_r;
  logic                       rd_vld_r;
  logic [SW-1:0]              sum_r;
  logic                       upd_r;
  logic                       out_tvalid_r;
  logic [FW-1:0]              out_rate_r;
  logic                       out_upd_r;

  logic [NW-1:0]              n_eff;
  logic [frwa_pkg::PER_W-1:0] period_eff;
  logic [FW-1:0]              t_in;
  logic [FW-1:0]              t_eff;
  logic [NW-1:0]              pos;
  logic [NW-1:0]              pos_inc;
  logic [frwa_pkg::PER_W-1:0] cnt_inc;
  logic                       in_acc;
  logic                       sum_done;
  logic                       store_busy;
  logic [FW-1:0]              rd_data;
  logic                       div_start;
  logic                       div_done;
  logic [NUMW-1:0]            div_num;
  logic [DENW-1:0]            div_den;
  logic [NUMW-1:0]            div_quo;

  always_comb begin
    if (win_len_r == '0) begin
      n_eff = NW'(1);
    end else if (int'(win_len_r) > MAX_SAMPLES) begin
      n_eff = NW'(MAX_SAMPLES);
    end else begin
      n_eff = NW'(win_len_r);
    end
  end

  assign period_eff = (period_r == '0) ? frwa_pkg::PER_W'(1) : period_r;
  assign t_in       = in_tdata[FW-1:0];
  assign t_eff      = (t_in == '0) ? frwa_pkg::DEFAULT_FRAME_US : t_in;
  // write position left past a shrunken window restarts at zero
  assign pos        = (NW'(wp_r) >= n_eff) ? '0 : NW'(wp_r);
  assign pos_inc    = ((pos + 1'b1) >= n_eff) ? '0 : pos + 1'b1;
  assign cnt_inc    = cnt_r + 1'b1;

  assign in_tready  = (state_r == ST_IDLE) && !store_busy;
  assign in_acc     = in_tvalid && in_tready;
  assign sum_done   = (state_r == ST_SUM) && (rd_idx_r == n_r) && !rd_vld_r;
  assign div_start  = sum_done && (sum_r != '0);
  assign div_num    = NUMW'(frwa_pkg::US_X2) * NUMW'(n_r) + NUMW'(sum_r);
  assign div_den    = {sum_r, 1'b0};

  frwa_store #(
    .DEPTH (MAX_SAMPLES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc),
    .wr_addr (pos[AW-1:0]),
    .wr_data (t_eff),
    .rd_addr (rd_idx_r[AW-1:0]),
    .rd_data (rd_data),
    .busy    (store_busy)
  );

  frwa_div #(
    .NUMW (NUMW),
    .DENW (DENW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      win_len_r    <= frwa_pkg::RESET_WINDOW;
      period_r     <= frwa_pkg::RESET_PERIOD;
      wp_r         <= '0;
      cnt_r        <= '0;
      held_r       <= frwa_pkg::RESET_RATE;
      n_r          <= '0;
      rd_idx_r     <= '0;
      rd_vld_r     <= 1'b0;
      upd_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          frwa_pkg::REG_WINDOW_LENGTH: win_len_r <= cfg_wdata[frwa_pkg::WIN_W-1:0];
          frwa_pkg::REG_UPDATE_PERIOD: period_r  <= cfg_wdata[frwa_pkg::PER_W-1:0];
          default: ;
        endcase
      end

      // in ST_OUT the result register is reloaded below instead
      if (out_tvalid_r && out_tready && (state_r != ST_OUT)) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            wp_r <= pos_inc[AW-1:0];
            n_r  <= n_eff;
            if (cnt_inc >= period_eff) begin
              cnt_r    <= '0;
              upd_r    <= 1'b1;
              rd_idx_r <= '0;
              rd_vld_r <= 1'b0;
              sum_r    <= '0;
              state_r  <= ST_SUM;
            end else begin
              cnt_r   <= cnt_inc;
              upd_r   <= 1'b0;
              state_r <= ST_OUT;
            end
          end
        end
        ST_SUM: begin
          // one read issued per cycle, data lands in the cycle after
          if (rd_idx_r < n_r) begin
            rd_idx_r <= rd_idx_r + 1'b1;
            rd_vld_r <= 1'b1;
          end else begin
            rd_vld_r <= 1'b0;
          end
          if (rd_vld_r) begin
            sum_r <= sum_r + SW'(rd_data);
          end
          if (sum_done) begin
            state_r <= (sum_r == '0) ? ST_OUT : ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            held_r  <= div_quo[FW-1:0];
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_rate_r   <= held_r;
            out_upd_r    <= upd_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0, out_rate_r};
  assign out_tuser  = out_upd_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_read_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUM |-> rd_idx_r <= n_r)
    else $error("sum read index ran past the window");

  a_wp_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> NW'(wp_r) < n_r)
    else $error("write position left outside the window");

  a_count_below_period: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> cnt_r < period_eff)
    else $error("frame count not below the update period after an item");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the frame rate window average block.
`timescale 1ns / 1ps

module tb;

  localparam int FW              = frwa_pkg::FW;
  localparam int WIN_W           = frwa_pkg::WIN_W;
  localparam int PER_W           = frwa_pkg::PER_W;
  localparam int CFG_AW          = frwa_pkg::CFG_AW;
  localparam int CFG_DW          = frwa_pkg::CFG_DW;
  localparam int MAX_SAMPLES_DEF = frwa_pkg::MAX_SAMPLES_DEF;

  localparam int LIMIT_CYCLES = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 300;
  localparam logic [FW-1:0] FIELD_MAX = 20'hFFFFF;

  typedef struct packed {
    logic [FW-1:0] fps;
    logic          updated;
  } fps_result_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [23:0]         in_tdata   = '0;   // [19:0] frame_time_us
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [23:0]         out_tdata;         // [19:0] frames_per_second
  logic                out_tuser;         // [0] rate_updated
  logic                cfg_wr_en  = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr   = frwa_pkg::REG_WINDOW_LENGTH;
  logic [CFG_DW-1:0]   cfg_wdata  = '0;

  // predictor state
  logic [WIN_W-1:0]    win_len_q;
  logic [PER_W-1:0]    period_q;
  logic [FW-1:0]       ring_q [MAX_SAMPLES_DEF];
  int unsigned         ring_pos;
  logic [PER_W-1:0]    frames_q;
  logic [FW-1:0]       held_fps;

  fps_result_t         expected_fps_q[$];
  fps_result_t         want;
  int unsigned         err_count     = 0;
  int unsigned         frames_sent   = 0;
  int unsigned         results_seen  = 0;
  int unsigned         updates_seen  = 0;
  int unsigned         quiet_cycles  = 0;
  bit                  sender_idle_en = 1'b1;
  bit                  sink_idle_en   = 1'b1;
  bit                  hold_req       = 1'b0;
  bit                  hold_done      = 1'b0;

  frame_rate_window_average DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void reset_meter();
    win_len_q = frwa_pkg::RESET_WINDOW;
    period_q  = frwa_pkg::RESET_PERIOD;
    foreach (ring_q[i]) ring_q[i] = frwa_pkg::DEFAULT_FRAME_US;
    ring_pos  = 0;
    frames_q  = '0;
    held_fps  = frwa_pkg::RESET_RATE;
  endfunction

  function automatic fps_result_t advance_meter(input logic [FW-1:0] t);
    int unsigned       n;
    int unsigned       per;
    int unsigned       pos;
    longint unsigned   sum;
    longint unsigned   q;
    logic [FW-1:0]     dur;
    fps_result_t       r;
    n = win_len_q;
    if (n == 0) n = 1;
    if (n > MAX_SAMPLES_DEF) n = MAX_SAMPLES_DEF;
    per = (period_q == 0) ? 1 : period_q;
    dur = (t == 0) ? frwa_pkg::DEFAULT_FRAME_US : t;
    // a shrunken window restarts the ring at slot 0
    pos = ring_pos;
    if (pos >= n) pos = 0;
    ring_q[pos] = dur;
    pos++;
    if (pos >= n) pos = 0;
    ring_pos = pos;
    frames_q = frames_q + 1'b1;
    r.updated = 1'b0;
    if (frames_q >= per) begin
      sum = 0;
      for (int i = 0; i < n; i++) sum += ring_q[i];
      if (sum != 0) begin
        q = (frwa_pkg::US_X2 * n + sum) / (2 * sum);   // rounded half up
        held_fps = q[FW-1:0];
      end
      frames_q  = '0;
      r.updated = 1'b1;
    end
    r.fps = held_fps;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint exp_v);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, exp_v, $realtime);
    err_count++;
  endtask

  task automatic send_frame(input logic [FW-1:0] t);
    int unsigned gap;
    if (sender_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, t};
    do @(posedge clk); while (!in_tready);
    expected_fps_q.insert(expected_fps_q.size(), advance_meter(t));
    frames_sent++;
  endtask

  // every item yields one result, so an empty queue means the block is idle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_fps_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_config(input logic [CFG_DW-1:0] win, input logic [CFG_DW-1:0] per);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= frwa_pkg::REG_WINDOW_LENGTH;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_addr  <= frwa_pkg::REG_UPDATE_PERIOD;
    cfg_wdata <= per;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_len_q = win[WIN_W-1:0];
    period_q  = per;
  endtask

  function automatic logic [FW-1:0] rand_frame_time();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return FW'($urandom_range(1, 100));
      2:       return FW'($urandom);
      3:       return ($urandom_range(0, 1) != 0) ? FIELD_MAX : FW'(1000000);
      default: return FW'($urandom_range(5000, 50000));
    endcase
  endfunction

  // default settings: first recompute on the 15th frame over a 60-deep window
  task automatic test_reset_defaults();
    send_frame('0);
    send_frame(FW'(1));
    send_frame(FIELD_MAX);
    send_frame(FW'(1000000));
    send_frame(20'h55555);
    send_frame(20'hAAAAA);
    repeat (9) send_frame(frwa_pkg::DEFAULT_FRAME_US);
    drain();
  endtask

  task automatic test_single_sample_window();
    load_config(16'd1, 16'd1);
    send_frame(FW'(1));
    send_frame(FW'(3));
    drain();
  endtask

  // window 0 acts as 1, period 0 as 1, window above the store saturates
  task automatic test_clamped_settings();
    load_config(16'd0, 16'd0);
    send_frame(frwa_pkg::DEFAULT_FRAME_US);
    drain();
    load_config(16'h00FF, 16'd1);
    send_frame(FW'(40000));
    drain();
  endtask

  task automatic test_window_shrink_and_period_drop();
    load_config(16'd128, 16'hFFFF);
    repeat (3) send_frame(FW'($urandom_range(8000, 30000)));
    drain();
    // write position now beyond the window
    load_config(16'd2, 16'hFFFF);
    repeat (2) send_frame(FW'($urandom_range(8000, 30000)));
    drain();
    // count already above the new period: next frame recomputes
    load_config(16'd2, 16'd3);
    send_frame(FW'(20000));
    drain();
  endtask

  task automatic test_backpressure();
    sender_idle_en = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_frame(rand_frame_time());
    drain();
    sender_idle_en = 1'b1;
  endtask

  task automatic test_random_phases(input int phases, input int items, input bit idle);
    logic [CFG_DW-1:0] win;
    logic [CFG_DW-1:0] per;
    sender_idle_en = idle;
    sink_idle_en   = idle;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 9))
        0:       win = 16'd1;
        1:       win = 16'd128;
        2:       win = 16'($urandom_range(0, 255));
        default: win = 16'($urandom_range(1, 128));
      endcase
      case ($urandom_range(0, 9))
        0:       per = 16'd1;
        1:       per = 16'hFFFF;
        2:       per = 16'($urandom_range(0, 65535));
        default: per = 16'($urandom_range(1, 40));
      endcase
      load_config(win, per);
      repeat (items) send_frame(rand_frame_time());
      drain();
    end
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned burst;
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 6);
        out_tready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_fps_q.size() == 0) begin
        report_mismatch("unexpected result, frames_per_second", out_tdata[FW-1:0], 0);
      end else begin
        want = expected_fps_q.pop_front();
        if (out_tdata[FW-1:0] != want.fps)
          report_mismatch("frames_per_second", out_tdata[FW-1:0], want.fps);
        if (out_tuser != want.updated)
          report_mismatch("rate_updated", out_tuser, want.updated);
        if (want.updated) updates_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= LIMIT_CYCLES) begin
        $display("watchdog: no item moved for %0d cycles", LIMIT_CYCLES);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    reset_meter();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_single_sample_window();
    test_clamped_settings();
    test_window_shrink_and_period_drop();
    test_random_phases(5, 155, 1'b1);
    test_backpressure();
    test_random_phases(4, 155, 1'b1);
    test_random_phases(3, 155, 1'b0);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d frames, %0d results checked, %0d rate recomputations",
             frames_sent, results_seen, updates_seen);
    $display("windows 0..255 and periods 0..65535, idle bursts and a long output hold-off");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
